// File: rtl/gzhp_pkg.sv
package gzhp_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int FIXED_LEN = 10;
	localparam int XLEN_END = 12;

	localparam logic [7:0] ID1 = 8'h1F;
	localparam logic [7:0] ID2 = 8'h8B;
	localparam logic [7:0] CM_DEFLATE = 8'h08;

	localparam logic [7:0] FL_HCRC = 8'h02;
	localparam logic [7:0] FL_EXTRA = 8'h04;
	localparam logic [7:0] FL_NAME = 8'h08;
	localparam logic [7:0] FL_COMMENT = 8'h10;
	localparam logic [7:0] FL_RESERVED = 8'hE0;

	typedef enum logic [3:0] {
		PH_FIXED = 4'd0,
		PH_XLEN_LO = 4'd1,
		PH_XLEN_HI = 4'd2,
		PH_EXTRA = 4'd3,
		PH_NAME = 4'd4,
		PH_COMMENT = 4'd5,
		PH_HCRC_A = 4'd6,
		PH_HCRC_B = 4'd7,
		PH_SWALLOW = 4'd8,
		PH_DONE = 4'd15
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NEED = 2'd1,
		ST_CORRUPT = 2'd2,
		ST_UNSUPPORTED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_input;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic [31:0] hdr_size;
		logic [31:0] bytes_needed;
	} out_item_t;

	function automatic phase_t next_phase(input phase_t from, input logic [7:0] flg);
		phase_t nxt;
		nxt = PH_DONE;
		if (from < PH_XLEN_LO && (flg & FL_EXTRA) != 8'h00) begin
			nxt = PH_XLEN_LO;
		end else if (from < PH_NAME && (flg & FL_NAME) != 8'h00) begin
			nxt = PH_NAME;
		end else if (from < PH_COMMENT && (flg & FL_COMMENT) != 8'h00) begin
			nxt = PH_COMMENT;
		end else if (from < PH_HCRC_A && (flg & FL_HCRC) != 8'h00) begin
			nxt = PH_HCRC_A;
		end
		return nxt;
	endfunction

endpackage

// File: rtl/gzip_member_header_parser.sv
// channel | valid      | ready      | word
// --------+------------+------------+------------------------------------------
// input   | byte_valid | byte_ready | byte_word (data_byte, end_of_input)
// result  | res_valid  | res_ready  | res_word  (status, hdr_size, bytes_needed)
//
// One word per cycle while the result register is free or being taken; a word lands in the
// input register when accepted, and its result, if any, is registered when that word advances.
// The parse state advances only while the result register is free or being taken.
// A stalled result holds the input register; byte_ready stays high while it is empty.
// Reset clears the parse state and both valid flags.
module gzip_member_header_parser import gzhp_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_ready,
	input in_item_t byte_word,
	output logic res_valid,
	input logic res_ready,
	output out_item_t res_word
);

	logic valid_s1;
	in_item_t word_s1;
	logic adv;
	logic emit;
	out_item_t res;
	logic res_valid_q;
	out_item_t res_q;

	assign adv = valid_s1 && (!res_valid_q || res_ready);
	assign byte_ready = !valid_s1 || adv;

	gzhp_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.fire(adv),
		.word(word_s1),
		.emit(emit),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) word_s1 <= byte_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) res_q <= res;
	end

	assign res_valid = res_valid_q;
	assign res_word = res_q;

	a_ok_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_OK |-> res_q.hdr_size == res_q.bytes_needed)
		else $error("ok result with differing sizes");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status == ST_CORRUPT || res_q.status == ST_UNSUPPORTED)
		|-> res_q.hdr_size == 32'd0 && res_q.bytes_needed == 32'd0)
		else $error("error result with nonzero sizes");

	a_need_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_NEED |-> res_q.hdr_size == 32'd0)
		else $error("need_more result with header size");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(word_s1))
		else $error("input register lost a stalled word");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> res_valid_q)
		else $error("emitted result not registered");

endmodule

// File: rtl/gzhp_step.sv
module gzhp_step import gzhp_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input in_item_t word,
	output logic emit,
	output out_item_t res
);

	localparam int P = POSITION_BITS;

	phase_t ph_q, ph_n;
	logic [P-1:0] pos_q, pos_inc, pos_n;
	logic [7:0] flags_q, flags_n;
	status_t err_q, err_n;
	logic [7:0] low_q, low_n;
	logic [15:0] rem_q, rem_n;

	logic [7:0] b;
	logic [16:0] need_add;
	logic [P:0] need_sum;
	logic [P-1:0] need_sat;
	logic [63:0] pos_wide, need_wide;

	assign b = word.data_byte;
	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + P'(1);

	always_comb begin
		ph_n = ph_q;
		pos_n = pos_inc;
		flags_n = flags_q;
		err_n = err_q;
		low_n = low_q;
		rem_n = rem_q;
		emit = 1'b0;
		res.status = ST_OK;
		res.hdr_size = 32'd0;
		res.bytes_needed = 32'd0;
		need_add = 17'd2;
		need_sum = '0;
		need_sat = '0;
		pos_wide = 64'(pos_inc);
		need_wide = '0;

		unique case (ph_q)
			PH_FIXED: begin
				priority if ((pos_q == P'(0) && b != ID1) || (pos_q == P'(1) && b != ID2)) begin
					if (err_n == ST_OK) err_n = ST_CORRUPT;
				end else if (pos_q == P'(2) && b != CM_DEFLATE) begin
					if (err_n == ST_OK) err_n = ST_UNSUPPORTED;
				end else if (pos_q == P'(3)) begin
					flags_n = b;
					if ((b & FL_RESERVED) != 8'h00 && err_n == ST_OK) err_n = ST_CORRUPT;
				end
				if (pos_inc >= P'(FIXED_LEN)) begin
					if (err_n != ST_OK) begin
						emit = 1'b1;
						res.status = err_n;
						ph_n = PH_SWALLOW;
					end else begin
						ph_n = next_phase(PH_FIXED, flags_n);
					end
				end
			end
			PH_XLEN_LO: begin
				low_n = b;
				ph_n = PH_XLEN_HI;
			end
			PH_XLEN_HI: begin
				rem_n = {b, low_q};
				ph_n = (rem_n == 16'd0) ? next_phase(PH_EXTRA, flags_q) : PH_EXTRA;
			end
			PH_EXTRA: begin
				rem_n = rem_q - 16'd1;
				if (rem_n == 16'd0) ph_n = next_phase(PH_EXTRA, flags_q);
			end
			PH_NAME, PH_COMMENT: begin
				if (b == 8'h00) ph_n = next_phase(ph_q, flags_q);
			end
			PH_HCRC_A: ph_n = PH_HCRC_B;
			PH_HCRC_B: ph_n = PH_DONE;
			default: ph_n = PH_SWALLOW;
		endcase

		if (ph_n == PH_DONE) begin
			emit = 1'b1;
			res.status = ST_OK;
			res.hdr_size = pos_wide[31:0];
			res.bytes_needed = pos_wide[31:0];
			ph_n = PH_SWALLOW;
		end

		if (word.end_of_input) begin
			if (!emit && ph_n != PH_SWALLOW) begin
				unique case (ph_n)
					PH_EXTRA: need_add = 17'(rem_n) + 17'd1;
					PH_HCRC_A: need_add = 17'd3;
					default: need_add = 17'd2;
				endcase
				need_sum = {1'b0, pos_q} + (P+1)'(need_add);
				need_sat = need_sum[P] ? '1 : need_sum[P-1:0];
				priority if (ph_n == PH_FIXED) begin
					need_wide = 64'(FIXED_LEN);
				end else if (ph_n == PH_XLEN_LO || ph_n == PH_XLEN_HI) begin
					need_wide = 64'(XLEN_END);
				end else begin
					need_wide = 64'(need_sat);
				end
				emit = 1'b1;
				res.status = ST_NEED;
				res.hdr_size = 32'd0;
				res.bytes_needed = need_wide[31:0];
			end
			ph_n = PH_FIXED;
			pos_n = '0;
			flags_n = 8'h00;
			err_n = ST_OK;
			low_n = 8'h00;
			rem_n = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_FIXED;
			pos_q <= '0;
			flags_q <= 8'h00;
			err_q <= ST_OK;
			low_q <= 8'h00;
			rem_q <= 16'd0;
		end else if (fire) begin
			ph_q <= ph_n;
			pos_q <= pos_n;
			flags_q <= flags_n;
			err_q <= err_n;
			low_q <= low_n;
			rem_q <= rem_n;
		end
	end

endmodule
